FILE: sv/cdpa_pkg.sv
// Shared types, constants and calendar helpers for the date period adder.
package cdpa_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    localparam logic [15:0] C_YEAR_MAX       = 16'hFFFF;
    localparam logic [3:0]  C_MONTHS_PER_YR  = 4'd12;
    localparam logic [3:0]  C_MONTH_FEB      = 4'd2;
    localparam logic [3:0]  C_MONTH_APR      = 4'd4;
    localparam logic [3:0]  C_MONTH_JUN      = 4'd6;
    localparam logic [3:0]  C_MONTH_SEP      = 4'd9;
    localparam logic [3:0]  C_MONTH_NOV      = 4'd11;
    localparam logic [4:0]  C_LEN_LONG       = 5'd31;
    localparam logic [4:0]  C_LEN_SHORT      = 5'd30;
    localparam logic [4:0]  C_LEN_FEB_LEAP   = 5'd29;
    localparam logic [4:0]  C_LEN_FEB_COMMON = 5'd28;

    // Divisibility by 25 of a 16-bit value: multiply by the inverse of 25
    // modulo 2^16 and check that the low half does not exceed 65535 / 25.
    localparam logic [15:0] C_INV25   = 16'd23593;
    localparam logic [15:0] C_LIM25   = 16'd2621;

    typedef struct packed {
        logic        operation;
        logic [15:0] year_field;
        logic [11:0] month_field;
        logic [15:0] day_field;
    } t_item;

    typedef struct packed {
        logic [15:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic        overflow;
        logic        invalid_load;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_CHK,
        S_ADD_YEAR,
        S_MONTH_WRAP,
        S_LEAP_WAIT,
        S_DAY_CARRY
    } t_state;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            C_MONTH_FEB: begin
                len = leap ? C_LEN_FEB_LEAP : C_LEN_FEB_COMMON;
            end
            C_MONTH_APR, C_MONTH_JUN, C_MONTH_SEP, C_MONTH_NOV: begin
                len = C_LEN_SHORT;
            end
            default: begin
                len = C_LEN_LONG;
            end
        endcase
        return len;
    endfunction

endpackage

FILE: sv/calendar_date_period_adder.sv
// Top level of the Gregorian date period adder: sequencer and date registers.
//
// The block holds one date (reset value January 1 of year 1) and takes one
// command beat when start is high and busy is low. A load beat checks the
// date in S_LOAD_CHK. An add beat adds the years in S_ADD_YEAR, then makes
// W month wraps in S_MONTH_WRAP, W = (month + month_field - 1) / 12, at
// most 342, waits in S_LEAP_WAIT, and makes D month carries in S_DAY_CARRY,
// at most about 2160 for a day_field of 65535. The day carry and the month
// wrap both run one step per cycle and share one saturating year incrementer;
// the day carry also subtracts the month length. The result beat sits
// on o_result for exactly one cycle, flagged by o_done, in the cycle after
// the last step; it cannot be held off, so the receiver must take it then.
// A new command may be issued in the same cycle as the result beat.
module calendar_date_period_adder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  cdpa_pkg::t_item i_item,
    output logic            o_done,
    output cdpa_pkg::t_result o_result
);
    import cdpa_pkg::*;

    t_state      r_state,  n_state;
    t_item       r_item,   n_item;
    logic [15:0] r_year,   n_year;
    logic [3:0]  r_month,  n_month;
    logic [4:0]  r_day,    n_day;
    logic [16:0] r_acc,    n_acc;
    logic [12:0] r_mcnt,   n_mcnt;
    logic        r_ovf,    n_ovf;
    logic        r_done,   n_done;
    t_result     r_result, n_result;

    logic [15:0] w_leap_year;
    logic        w_leap;
    logic [15:0] w_year_inc;
    logic        w_year_sat;
    logic [16:0] w_year_sum;
    logic [4:0]  w_len;
    logic [4:0]  w_load_len;
    logic        w_load_ok;
    logic [3:0]  w_month_next;

    // The leap flag is registered, so it trails the year it was given. During
    // the command beat it looks at the incoming year so that the load check has
    // it ready in the next cycle.
    assign w_leap_year = (r_state == S_IDLE) ? i_item.year_field : r_year;

    cdpa_leap u_leap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_year  (w_leap_year),
        .o_leap  (w_leap)
    );

    // Saturating one-year step, shared by the month wrap and the day carry.
    assign w_year_sat = (r_year == C_YEAR_MAX);
    assign w_year_inc = w_year_sat ? r_year : r_year + 16'd1;

    assign w_year_sum = {1'b0, r_year} + {1'b0, r_item.year_field};

    // Length of the current month. Only January follows a year change in
    // the day carry, and its length does not depend on the leap flag, so the
    // flag has caught up by the time February is reached.
    assign w_len = month_len(r_month, w_leap);

    assign w_month_next = (r_month >= C_MONTHS_PER_YR) ? 4'd1 : r_month + 4'd1;

    assign w_load_len = month_len(r_item.month_field[3:0], w_leap);
    assign w_load_ok  = (r_item.year_field != 16'd0) &&
                        (r_item.month_field >= 12'd1) &&
                        (r_item.month_field <= {8'd0, C_MONTHS_PER_YR}) &&
                        (r_item.day_field >= 16'd1) &&
                        (r_item.day_field <= {11'd0, w_load_len});

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_acc    = r_acc;
        n_mcnt   = r_mcnt;
        n_ovf    = r_ovf;
        n_done   = 1'b0;
        n_result = r_result;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_ovf   = 1'b0;
                    n_state = (i_item.operation == OP_ADD) ? S_ADD_YEAR : S_LOAD_CHK;
                end
            end

            S_LOAD_CHK: begin
                // A rejected load keeps and reports the stored date.
                if (w_load_ok) begin
                    n_year  = r_item.year_field;
                    n_month = r_item.month_field[3:0];
                    n_day   = r_item.day_field[4:0];
                end
                n_result.year_out     = w_load_ok ? r_item.year_field : r_year;
                n_result.month_out    = w_load_ok ? r_item.month_field[3:0] : r_month;
                n_result.day_out      = w_load_ok ? r_item.day_field[4:0] : r_day;
                n_result.overflow     = 1'b0;
                n_result.invalid_load = ~w_load_ok;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            S_ADD_YEAR: begin
                if (w_year_sum[16]) begin
                    n_year = C_YEAR_MAX;
                    n_ovf  = 1'b1;
                end else begin
                    n_year = w_year_sum[15:0];
                end
                // Zero-based month count, and the day sum before carrying.
                n_mcnt  = {9'd0, r_month} + {1'b0, r_item.month_field} - 13'd1;
                n_acc   = {12'd0, r_day} + {1'b0, r_item.day_field};
                n_state = S_MONTH_WRAP;
            end

            S_MONTH_WRAP: begin
                if (r_mcnt >= {9'd0, C_MONTHS_PER_YR}) begin
                    n_mcnt = r_mcnt - {9'd0, C_MONTHS_PER_YR};
                    n_year = w_year_inc;
                    if (w_year_sat) begin
                        n_ovf = 1'b1;
                    end
                end else begin
                    n_month = r_mcnt[3:0] + 4'd1;
                    n_state = S_LEAP_WAIT;
                end
            end

            S_LEAP_WAIT: begin
                n_state = S_DAY_CARRY;
            end

            S_DAY_CARRY: begin
                if (r_acc > {12'd0, w_len}) begin
                    n_acc   = r_acc - {12'd0, w_len};
                    n_month = w_month_next;
                    if (r_month >= C_MONTHS_PER_YR) begin
                        n_year = w_year_inc;
                        if (w_year_sat) begin
                            n_ovf = 1'b1;
                        end
                    end
                end else begin
                    n_day = r_acc[4:0];
                    n_result.year_out     = r_year;
                    n_result.month_out    = r_month;
                    n_result.day_out      = r_acc[4:0];
                    n_result.overflow     = r_ovf;
                    n_result.invalid_load = 1'b0;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and the stored date are reset; working registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_year  <= 16'd1;
            r_month <= 4'd1;
            r_day   <= 5'd1;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_acc    <= n_acc;
        r_mcnt   <= n_mcnt;
        r_ovf    <= n_ovf;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: sv/cdpa_leap.sv
// Registered Gregorian leap-year test of a 16-bit year.
module cdpa_leap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_year,
    output logic        o_leap
);
    import cdpa_pkg::*;

    logic [31:0] w_prod;
    logic        w_div4;
    logic        w_div16;
    logic        w_div25;
    logic        n_leap;
    logic        r_leap;

    assign w_prod  = {16'd0, i_year} * {16'd0, C_INV25};
    assign w_div4  = (i_year[1:0] == 2'd0);
    assign w_div16 = (i_year[3:0] == 4'd0);
    assign w_div25 = (w_prod[15:0] <= C_LIM25);

    // Divisible by 400, or by 4 but not by 100.
    assign n_leap = (w_div16 & w_div25) | (w_div4 & ~w_div25);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leap <= 1'b0;
        end else begin
            r_leap <= n_leap;
        end
    end

    assign o_leap = r_leap;

endmodule

FILE: sv/cdpa_checker.sv
// Port-level assertions for the date period adder, bound to the top level.
module cdpa_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input cdpa_pkg::t_result o_result
);
    import cdpa_pkg::*;

    // An accepted command beat always makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command beat accepted but block not busy");

    // A result beat is only issued once the block is free again.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("result beat while busy or without prior work");

    // Every reported date has a nonzero year, a month from 1 to 12 and a nonzero day.
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.year_out != 16'd0 && o_result.month_out >= 4'd1 &&
                    o_result.month_out <= C_MONTHS_PER_YR && o_result.day_out >= 5'd1))
        else $error("result date out of range");

    // Overflow only comes from an add, and only with the year pinned at the top.
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.overflow) |->
            (o_result.year_out == C_YEAR_MAX && !o_result.invalid_load))
        else $error("overflow without saturated year");

endmodule

bind calendar_date_period_adder cdpa_checker u_cdpa_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

FILE: tb/calendar_date_period_adder_tb.sv
// Self-checking testbench for the Gregorian date period adder.
module calendar_date_period_adder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdpa_pkg::*;

    // A day add of 65535 makes about 2160 month carries and a month add of
    // 4095 about 342 wraps, and a single add keeps the block busy through all
    // of them with no beat moving at all. The watchdog allows several times the
    // length of such an add before it declares a hang.
    localparam int unsigned STALL_LIMIT = 20000;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   cmd_bus = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    // Calendar state of the predictor; it mirrors the date held by the block.
    int unsigned cal_year;
    int unsigned cal_month;
    int unsigned cal_day;
    bit          year_clamped;

    // Every accepted command beat leaves one predicted date here, oldest first.
    t_result     pending_dates[$];
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles   = 0;
    bit          gapless        = 1'b0;

    calendar_date_period_adder u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (cmd_bus),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    // Gregorian leap rule: every 400th year, or every 4th that is not a
    // century.
    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y,
                                                  input int unsigned m);
        int unsigned len;
        if (m == C_MONTH_FEB) begin
            len = leap_year(y) ? C_LEN_FEB_LEAP : C_LEN_FEB_COMMON;
        end else if (m == C_MONTH_APR || m == C_MONTH_JUN ||
                     m == C_MONTH_SEP || m == C_MONTH_NOV) begin
            len = C_LEN_SHORT;
        end else begin
            len = C_LEN_LONG;
        end
        return len;
    endfunction

    // Every year increment goes through here: the year holds at its maximum
    // and the clamp is remembered for the overflow flag of the result.
    function automatic void bump_year(input int unsigned n);
        cal_year = cal_year + n;
        if (cal_year > C_YEAR_MAX) begin
            cal_year     = C_YEAR_MAX;
            year_clamped = 1'b1;
        end
    endfunction

    // Applies one command beat to the predicted calendar and returns the
    // date the block must report for it.
    function automatic t_result advance_calendar(input t_item cmd);
        t_result     res;
        int unsigned total;
        int unsigned day;
        int unsigned len;
        bit          rejected;
        rejected     = 1'b0;
        year_clamped = 1'b0;
        if (cmd.operation == OP_LOAD) begin
            // The short-circuit keeps days_in_month away from bad months.
            if (cmd.year_field != 0 && cmd.month_field >= 1 &&
                cmd.month_field <= C_MONTHS_PER_YR && cmd.day_field >= 1 &&
                cmd.day_field <= days_in_month(cmd.year_field, cmd.month_field)) begin
                cal_year  = cmd.year_field;
                cal_month = cmd.month_field;
                cal_day   = cmd.day_field;
            end else begin
                rejected = 1'b1;
            end
        end else begin
            bump_year(cmd.year_field);
            total     = cal_month + cmd.month_field;
            bump_year((total - 1) / C_MONTHS_PER_YR);
            cal_month = (total - 1) % C_MONTHS_PER_YR + 1;
            // A day beyond its month after the month add is folded into the
            // same carry walk as the added days.
            day = cal_day + cmd.day_field;
            len = days_in_month(cal_year, cal_month);
            while (day > len) begin
                day = day - len;
                if (cal_month >= C_MONTHS_PER_YR) begin
                    cal_month = 1;
                    bump_year(1);
                end else begin
                    cal_month = cal_month + 1;
                end
                len = days_in_month(cal_year, cal_month);
            end
            cal_day = day;
        end
        res.year_out     = 16'(cal_year);
        res.month_out    = 4'(cal_month);
        res.day_out      = 5'(cal_day);
        res.overflow     = year_clamped;
        res.invalid_load = rejected;
        return res;
    endfunction

    function automatic t_item make_item(input logic op, input int unsigned y,
                                        input int unsigned m, input int unsigned d);
        t_item it;
        it.operation   = op;
        it.year_field  = 16'(y);
        it.month_field = 12'(m);
        it.day_field   = 16'(d);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Presents one command beat and holds it until the block takes it. Start
    // is left high so that a following beat can go out back to back; gaps
    // lower it explicitly.
    task automatic send_beat(input t_item cmd);
        start   <= 1'b1;
        cmd_bus <= cmd;
        do @(posedge i_clk); while (busy);
        pending_dates.push_back(advance_calendar(cmd));
    endtask

    // Random sender idling, in about a third of the beats, so that quiet
    // cycles land both while the block is still walking and after it is done.
    task automatic maybe_pause();
        if (!gapless && $urandom_range(99) < 32) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
    endtask

    task automatic issue(input logic op, input int unsigned y,
                         input int unsigned m, input int unsigned d);
        maybe_pause();
        send_beat(make_item(op, y, m, d));
    endtask

    // ------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------

    task automatic compare_field(input string fname, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            mismatch_count++;
        end
    endtask

    // A result beat is on the ports for one cycle only, so it is taken at
    // every edge where the done strobe is seen high.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_dates.size() == 0) begin
                $error("result beat with no command outstanding");
                mismatch_count++;
            end else begin
                want = pending_dates.pop_front();
                compare_field("year_out", want.year_out, o_result.year_out);
                compare_field("month_out", want.month_out, o_result.month_out);
                compare_field("day_out", want.day_out, o_result.day_out);
                compare_field("overflow", want.overflow, o_result.overflow);
                compare_field("invalid_load", want.invalid_load,
                              o_result.invalid_load);
            end
        end
    end

    // Counts edges at which no beat moves in either direction.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Adding nothing to the reset date must return January 1 of year 1.
    task automatic test_zero_period();
        issue(OP_ADD, 0, 0, 0);
    endtask

    // Loads at the edges of the valid range and every way a load can be
    // rejected; a rejected load must report the date it kept.
    task automatic test_load_checks();
        issue(OP_LOAD, 65535, 12, 31);
        issue(OP_LOAD, 1, 1, 1);
        issue(OP_LOAD, 2000, 2, 29);
        issue(OP_LOAD, 1900, 2, 29);
        issue(OP_LOAD, 2024, 2, 29);
        issue(OP_LOAD, 2023, 2, 29);
        issue(OP_LOAD, 0, 6, 15);
        issue(OP_LOAD, 2020, 0, 1);
        issue(OP_LOAD, 2020, 13, 1);
        issue(OP_LOAD, 2020, 4095, 1);
        issue(OP_LOAD, 2020, 5, 0);
        issue(OP_LOAD, 2020, 4, 31);
        issue(OP_LOAD, 2020, 1, 65535);
    endtask

    // A day left beyond the end of a short month is carried onward: the end
    // of January plus a month lands in March, and a leap day plus a year
    // becomes March 1.
    task automatic test_month_end();
        issue(OP_LOAD, 2023, 1, 31);
        issue(OP_ADD, 0, 1, 0);
        issue(OP_LOAD, 2024, 1, 31);
        issue(OP_ADD, 0, 1, 0);
        issue(OP_LOAD, 2024, 2, 29);
        issue(OP_ADD, 1, 0, 0);
    endtask

    // Year saturation from a day carry, then the largest period of all.
    task automatic test_year_saturation();
        drain_results();
        issue(OP_LOAD, 65535, 12, 31);
        issue(OP_ADD, 0, 0, 1);
        issue(OP_ADD, 65535, 4095, 65535);
    endtask

    // Mostly adds of modest size mixed with valid loads, with a few huge
    // periods, near-maximum years and unconstrained loads mixed in.
    task automatic test_random_traffic(input int unsigned beats);
        int unsigned pick;
        int unsigned y;
        int unsigned m;
        int unsigned d;
        for (int unsigned n = 0; n < beats; n++) begin
            gapless = (n >= 100 && n < 160);
            if (n == 60 || n == 180) drain_results();
            pick = $urandom_range(99);
            if (pick < 15) begin
                case ($urandom_range(2))
                    0: y = $urandom_range(65535 - 40, 65535);
                    1: y = $urandom_range(1, 65535);
                    default: y = $urandom_range(1, 3000);
                endcase
                m = $urandom_range(1, 12);
                d = $urandom_range(1, days_in_month(y, m));
                issue(OP_LOAD, y, m, d);
            end else if (pick < 22) begin
                issue(OP_LOAD, $urandom_range(0, 65535), $urandom_range(0, 4095),
                      $urandom_range(0, 65535));
            end else begin
                pick = $urandom_range(99);
                y = (pick < 80) ? $urandom_range(0, 3) :
                    (pick < 95) ? $urandom_range(0, 400) : $urandom_range(0, 65535);
                pick = $urandom_range(99);
                m = (pick < 70) ? $urandom_range(0, 14) :
                    (pick < 92) ? $urandom_range(0, 120) : $urandom_range(0, 4095);
                pick = $urandom_range(99);
                d = (pick < 75) ? $urandom_range(0, 70) :
                    (pick < 96) ? $urandom_range(0, 1500) : $urandom_range(0, 65535);
                issue(OP_ADD, y, m, d);
            end
        end
        gapless = 1'b0;
    endtask

    initial begin
        cal_year     = 1;
        cal_month    = 1;
        cal_day      = 1;
        year_clamped = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_period();
        test_load_checks();
        test_month_end();
        test_year_saturation();
        test_random_traffic(217);

        // Let the last walk finish, then give a stray beat time to show up.
        drain_results();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
